// ===== rtl/odo_pkg.sv =====
`timescale 1ns / 1ps

package odo_pkg;

  // cordic iteration count, capped at the arctangent table length
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_COUNT   = 30;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int ITER_W       = 5;

  // cordic start value, reciprocal of the infinite-iteration gain in Q30
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN = 2'd1;

  localparam logic [15:0] HALF_RADIUS_RST  = 16'd1966;
  localparam logic [31:0] HEADING_GAIN_RST = 32'd102534791;

  typedef struct packed {
    logic signed [15:0] dphi_left;
    logic signed [15:0] dphi_right;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic        [31:0] heading;
    logic        [31:0] path_distance;
  } odo_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              mul;
    logic              head;
    logic              iter;
    logic [ITER_W-1:0] iter_idx;
    logic              scale;
    logic              acc;
  } odo_cmd_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic signed [32:0] atan_bam(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// ===== rtl/odo_ctrl.sv =====
`timescale 1ns / 1ps

module odo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output odo_pkg::odo_cmd_t cmd
);
  import odo_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_HEAD  = 6'b000100,
    ST_ITER  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_ACC   = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [ITER_W-1:0] iter_cnt;
  logic              slot_free;
  logic              last_iter;

  assign slot_free = !out_valid || out_ready;
  assign last_iter = (iter_cnt == ITER_W'(CORDIC_ITERS - 1));
  assign in_ready  = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_HEAD;
      ST_HEAD:  state_next = ST_ITER;
      ST_ITER:  if (last_iter) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_ACC;
      ST_ACC:   if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.mul      = (state == ST_MUL);
    cmd.head     = (state == ST_HEAD);
    cmd.iter     = (state == ST_ITER);
    cmd.iter_idx = iter_cnt;
    cmd.scale    = (state == ST_SCALE);
    cmd.acc      = (state == ST_ACC) && slot_free;
  end

  // state, iteration count and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.head) begin
        iter_cnt <= '0;
      end else if (cmd.iter) begin
        iter_cnt <= iter_cnt + 1'b1;
      end
      if (cmd.acc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/odo_dpath.sv =====
`timescale 1ns / 1ps

module odo_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  odo_pkg::odo_cmd_t             cmd,
  input  odo_pkg::odo_in_t              in_data,
  input  logic                          cfg_wr_en,
  input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output odo_pkg::odo_out_t             out_data
);
  import odo_pkg::*;

  // configuration
  logic [15:0] half_radius;
  logic [31:0] heading_gain;

  // architectural state
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading_angle;
  logic        [31:0] distance_total;

  // work registers
  logic signed [15:0] dl, dr;
  logic        [31:0] hstep;
  logic signed [17:0] travel;
  logic signed [17:0] travel_eff;
  logic signed [31:0] cx, cy;
  logic signed [32:0] cz;
  logic signed [49:0] prod_x, prod_y;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_radius  <= HALF_RADIUS_RST;
      heading_gain <= HEADING_GAIN_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_HALF_RADIUS) begin
        half_radius <= cfg_data[15:0];
      end else if (cfg_index == REG_HEADING_GAIN) begin
        heading_gain <= cfg_data;
      end
    end
  end

  // heading step and travel products
  logic signed [16:0] wdiff, wsum;
  logic signed [49:0] hprod;
  logic signed [33:0] tprod;

  assign wdiff = 17'(dr) - 17'(dl);
  assign wsum  = 17'(dr) + 17'(dl);
  assign hprod = 50'($signed({1'b0, heading_gain})) * 50'(wdiff);
  assign tprod = 34'($signed({1'b0, half_radius})) * 34'(wsum);

  // new heading and quadrant fold
  logic [31:0] head_new;
  logic        flip;
  logic [31:0] folded;

  assign head_new = heading_angle + hstep;
  assign flip     = head_new[31] ^ head_new[30];
  assign folded   = flip ? {~head_new[31], head_new[30:0]} : head_new;

  // one cordic rotation
  logic signed [31:0] xs, ys;
  logic signed [32:0] atan_i;

  assign xs     = cx >>> cmd.iter_idx;
  assign ys     = cy >>> cmd.iter_idx;
  assign atan_i = atan_bam(cmd.iter_idx);

  // position and distance accumulation
  logic signed [19:0] dx, dy;
  logic signed [32:0] sum_x, sum_y;
  logic        [16:0] abs_travel;
  logic        [32:0] dist_sum;
  logic signed [31:0] pos_x_next, pos_y_next;
  logic        [31:0] dist_next;

  assign dx         = prod_x[49:30];
  assign dy         = prod_y[49:30];
  assign sum_x      = 33'(pos_x) + 33'(dx);
  assign sum_y      = 33'(pos_y) + 33'(dy);
  assign abs_travel = travel[17] ? 17'(-travel) : travel[16:0];
  assign dist_sum   = {1'b0, distance_total} + 33'(abs_travel);

  always_comb begin
    if (sum_x[32] != sum_x[31]) begin
      pos_x_next = sum_x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      pos_x_next = sum_x[31:0];
    end
    if (sum_y[32] != sum_y[31]) begin
      pos_y_next = sum_y[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      pos_y_next = sum_y[31:0];
    end
    dist_next = dist_sum[32] ? 32'hffff_ffff : dist_sum[31:0];
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x          <= '0;
      pos_y          <= '0;
      heading_angle  <= '0;
      distance_total <= '0;
    end else begin
      if (cmd.head) begin
        heading_angle <= head_new;
      end
      if (cmd.acc) begin
        pos_x          <= pos_x_next;
        pos_y          <= pos_y_next;
        distance_total <= dist_next;
      end
    end
  end

  // work registers and output beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dl <= in_data.dphi_left;
      dr <= in_data.dphi_right;
    end
    if (cmd.mul) begin
      hstep  <= hprod[47:16];
      travel <= tprod[33:16];
    end
    if (cmd.head) begin
      cx         <= CORDIC_GAIN_Q30;
      cy         <= '0;
      cz         <= 33'($signed(folded));
      travel_eff <= flip ? -travel : travel;
    end
    if (cmd.iter) begin
      if (!cz[32]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_i;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_i;
      end
    end
    if (cmd.scale) begin
      prod_x <= 50'(travel_eff) * 50'(cx);
      prod_y <= 50'(travel_eff) * 50'(cy);
    end
    if (cmd.acc) begin
      out_data.x_pos         <= pos_x_next;
      out_data.y_pos         <= pos_y_next;
      out_data.heading       <= heading_angle;
      out_data.path_distance <= dist_next;
    end
  end

endmodule

// ===== rtl/diff_drive_odometry_unit.sv =====
`timescale 1ns / 1ps

// Differential-drive dead-reckoning odometry.
// Input channel (in_valid/in_ready/in_data): one beat carries the left and
// right wheel angle increments of one control period.
// Output channel (out_valid/out_ready/out_data): one beat per input beat with
// x, y, heading and path distance after that increment.
// Configuration: cfg_wr_en/cfg_index/cfg_data write half_radius (index 0) or
// heading_gain (index 1); write only while no item is in flight.
// The result beat follows one multiply step, one heading update, 16 iterations
// of a single shared cordic rotation stage, one scaling multiply and one
// accumulate step. A new input beat is taken only in the idle state, after
// the accumulate step of the previous item.
// The output register holds one finished result; while the receiver stalls,
// the next item may be taken and processed, and it waits in its accumulate
// step until the held result leaves.
// Reset: pose, heading and distance clear to zero, the configuration
// registers take their defaults, no output beat is pending.

module diff_drive_odometry_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  odo_pkg::odo_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output odo_pkg::odo_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import odo_pkg::*;

  odo_cmd_t cmd;

  // sequencer
  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and state
  odo_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
